/* hw/rtl/utf8ds_pkg.sv */
// shared types and constants of the six-byte utf-8 decoder
// no dependencies; imported by every other file of the block
package utf8ds_pkg;

  // longest sequence the decoder accepts, from four to six bytes
  localparam int unsigned MaxSeqBytes = 6;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned RemW  = 3;
  localparam int unsigned CntW  = 4;

  localparam logic [ByteW-1:0] ContMask  = 8'b1100_0000;
  localparam logic [ByteW-1:0] ContMark  = 8'b1000_0000;
  localparam logic [ByteW-1:0] LeadMask  = 8'b0111_1111;
  localparam logic [ByteW-1:0] ContBits  = 8'b0011_1111;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadLead = 2'd1,
    StBadCont = 2'd2,
    StTrunc   = 2'd3
  } status_t;

  // outcome of decoding one word
  typedef struct packed {
    logic           has;
    logic [CpW-1:0] code_point;
    status_t        status;
    logic           stream_end;
  } res_t;

endpackage

/* hw/rtl/utf8ds_in_reg.sv */
// input register of the decoder: holds one word until the decode stage takes it
// depends on utf8ds_pkg
module utf8ds_in_reg import utf8ds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  input  logic             consume,
  output logic             in_stall,
  output logic             a_valid,
  output logic [ByteW-1:0] a_byte,
  output logic             a_last
);

  logic accept;

  assign in_stall = a_valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (consume) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte <= data_byte;
      a_last <= last_byte;
    end
  end

endmodule

/* hw/rtl/utf8ds_core.sv */
// decode stage: sequence state and the per-word decode logic
// depends on utf8ds_pkg
module utf8ds_core import utf8ds_pkg::*; #(
  parameter int unsigned MaxSeqLen = MaxSeqBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             consume,
  input  logic [ByteW-1:0] a_byte,
  input  logic             a_last,
  output res_t             res
);

  logic [CpW-1:0]  accumulator, accumulator_next;
  logic [RemW-1:0] bytes_remaining, bytes_remaining_next;
  logic [CntW-1:0] n_ones;
  logic [CpW-1:0]  acc_shift;
  logic [RemW-1:0] rem_dec;

  function automatic logic [CntW-1:0] leading_ones(input logic [ByteW-1:0] b);
    logic [CntW-1:0] n;
    priority casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  assign n_ones    = leading_ones(a_byte);
  assign acc_shift = {accumulator[CpW-7:0], a_byte[5:0]};
  assign rem_dec   = bytes_remaining - RemW'(1);

  always_comb begin
    res.has              = 1'b0;
    res.code_point       = '0;
    res.status           = StOk;
    res.stream_end       = a_last;
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    if (bytes_remaining == '0) begin
      if (n_ones == '0) begin
        res.has        = 1'b1;
        res.code_point = CpW'(a_byte);
      end else if (n_ones == CntW'(1) || n_ones > CntW'(MaxSeqLen)) begin
        res.has              = 1'b1;
        res.status           = StBadLead;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
      end else if (a_last) begin
        // lead on the final word: sequence can never finish
        res.has              = 1'b1;
        res.status           = StTrunc;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
      end else begin
        accumulator_next     = CpW'(a_byte & (LeadMask >> n_ones));
        bytes_remaining_next = RemW'(n_ones - CntW'(1));
      end
    end else begin
      if ((a_byte & ContMask) != ContMark) begin
        res.has              = 1'b1;
        res.status           = StBadCont;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
      end else if (rem_dec == '0) begin
        res.has              = 1'b1;
        res.code_point       = acc_shift;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
      end else if (a_last) begin
        res.has              = 1'b1;
        res.status           = StTrunc;
        accumulator_next     = '0;
        bytes_remaining_next = '0;
      end else begin
        accumulator_next     = acc_shift;
        bytes_remaining_next = rem_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
    end else if (consume) begin
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

/* hw/rtl/utf8ds_out_reg.sv */
// result register of the decoder, loaded from the decode stage
// depends on utf8ds_pkg
module utf8ds_out_reg import utf8ds_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  res_t           res,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           free,
  output logic [CpW-1:0] code_point,
  output logic [1:0]     status,
  output logic           stream_end
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= res.code_point;
      status     <= res.status;
      stream_end <= res.stream_end;
    end
  end

endmodule

/* hw/rtl/utf8_decoder_six_byte.sv */
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// input    | in_valid / in_stall  | data_byte[7:0], last_byte
// output   | out_valid / out_stall| code_point[30:0], status[1:0], stream_end
//
// one word is taken every cycle while in_stall is low; a result passes through
// the input register, the decode logic and the result register
// words that only extend a sequence never wait for room at the output
// rst is synchronous and active high; it empties both registers and
// clears the sequence state
// out_stall reaches in_stall only when a waiting word would give a result
//
// top level of the six-byte utf-8 decoder; depends on utf8ds_pkg,
// utf8ds_in_reg, utf8ds_core and utf8ds_out_reg
module utf8_decoder_six_byte import utf8ds_pkg::*; #(
  // longest sequence accepted, four to six bytes
  parameter int unsigned MaxSeqLen = MaxSeqBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CpW-1:0]   code_point,
  output logic [1:0]       status,
  output logic             stream_end
);

  logic             a_valid;
  logic [ByteW-1:0] a_byte;
  logic             a_last;
  logic             consume;
  logic             out_free;
  res_t             res;

  // a word leaves the input register when it gives no result, or the
  // result register can take what it gives
  assign consume = a_valid && (!res.has || out_free);

  utf8ds_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .consume   (consume),
    .in_stall  (in_stall),
    .a_valid   (a_valid),
    .a_byte    (a_byte),
    .a_last    (a_last)
  );

  // sequence state advances only on the word actually consumed
  utf8ds_core #(
    .MaxSeqLen (MaxSeqLen)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .a_byte  (a_byte),
    .a_last  (a_last),
    .res     (res)
  );

  utf8ds_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (consume && res.has),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .free       (out_free),
    .code_point (code_point),
    .status     (status),
    .stream_end (stream_end)
  );

endmodule

/* hw/rtl/utf8ds_checker.sv */
// port-level checks for the six-byte utf-8 decoder, bound to the top level
// depends on utf8ds_pkg and utf8_decoder_six_byte
module utf8ds_checker import utf8ds_pkg::*; (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input logic [CpW-1:0] code_point,
  input logic [1:0]     status,
  input logic           stream_end
);

  // an error result carries no code point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != StOk |-> code_point == '0)
    else $error("error result with nonzero code point");

  // truncation is only ever reported at the end of the stream
  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == StTrunc |-> stream_end)
    else $error("truncated result without stream end");

  // an empty result register never holds back the input
  a_no_idle_stall: assert property (@(posedge clk)
    !out_valid |-> !in_stall)
    else $error("input stalled with result register empty");

  // a stalled result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(status)
      && $stable(stream_end))
    else $error("stalled result changed");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_decoder_six_byte utf8ds_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .code_point (code_point),
  .status     (status),
  .stream_end (stream_end)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for utf8_decoder_six_byte: directed table, then random byte streams
// depends on utf8ds_pkg and the decoder rtl; results are checked against a local predictor or typed-in rows
module tb import utf8ds_pkg::*; ();

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;
  logic             out_valid;
  logic             out_stall;
  logic [CpW-1:0]   code_point;
  logic [1:0]       status;
  logic             stream_end;

  utf8_decoder_six_byte dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .status     (status),
    .stream_end (stream_end)
  );

  // one row of the directed stimulus; want is used only when fixed is set
  typedef struct {
    logic [ByteW-1:0] b;
    logic             fin;
    bit               fixed;
    res_t             want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  // expected results still to come out of the block, oldest first
  res_t pending_cps[$];

  // predictor state: payload bits gathered and continuation words still owed
  logic [CpW-1:0]  seq_acc;
  logic [RemW-1:0] seq_left;

  // what the word on the input port should produce, set by the sender
  bit   cur_fixed;
  res_t cur_want;

  int n_errors;

  // pressure handshakes between the sender and the receiver process
  bit hold_req;
  bit hold_active;

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous ceiling on run time, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    n_errors++;
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // predictor: feeds one word through the decoder state and returns the result it causes
  function automatic res_t decode_word(input logic [ByteW-1:0] b, input logic fin);
    res_t r;
    int   ones;
    r = '0;
    r.stream_end = fin;
    if (seq_left == 0) begin
      ones = 0;
      while (ones < 8 && b[7-ones]) ones++;
      // plain ascii passes straight through
      if (ones == 0) begin
        r.has = 1'b1;
        r.code_point = CpW'(b);
        return r;
      end
      // stray continuation, 1111111x, or a lead longer than the decoder allows
      if (ones == 1 || ones > MaxSeqBytes) begin
        seq_acc  = '0;
        seq_left = '0;
        r.has    = 1'b1;
        r.status = StBadLead;
        return r;
      end
      seq_acc  = CpW'(b & (8'h7F >> ones));
      seq_left = RemW'(ones - 1);
    end else begin
      // anything but 10xxxxxx inside a sequence is dropped with an error
      if ((b & ContMask) != ContMark) begin
        seq_acc  = '0;
        seq_left = '0;
        r.has    = 1'b1;
        r.status = StBadCont;
        return r;
      end
      seq_acc  = {seq_acc[CpW-7:0], b[5:0]};
      seq_left = seq_left - 1'b1;
      if (seq_left == 0) begin
        r.has        = 1'b1;
        r.code_point = seq_acc;
        seq_acc      = '0;
        return r;
      end
    end
    // stream ended with a sequence still open
    if (fin) begin
      seq_acc      = '0;
      seq_left     = '0;
      r.has        = 1'b1;
      r.status     = StTrunc;
      r.stream_end = 1'b1;
    end
    return r;
  endfunction

  // gap lengths: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // monitor: outputs are checked before the new word is predicted, both at the rising edge
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_cps.size() == 0) begin
          report_mismatch("unexpected result, code point", 0, code_point);
        end else begin
          want = pending_cps.pop_front();
          if (code_point !== want.code_point)
            report_mismatch("code_point", want.code_point, code_point);
          if (status !== 2'(want.status))
            report_mismatch("status", want.status, status);
          if (stream_end !== want.stream_end)
            report_mismatch("stream_end", want.stream_end, stream_end);
        end
      end
      if (in_valid && !in_stall) begin
        got = decode_word(data_byte, last_byte);
        // typed-in rows override the predictor, which still tracks the state
        if (cur_fixed) got = cur_want;
        if (got.has) pending_cps = {pending_cps, got};
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold on request
  initial begin : receiver
    int stall_left;
    int calm_left;
    int r;
    stall_left  = 0;
    calm_left   = 0;
    hold_active = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        stall_left  = 120;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        hold_active = 1'b0;
        if (calm_left > 0) begin
          out_stall <= 1'b0;
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            calm_left = $urandom_range(30, 100);
            out_stall <= 1'b0;
          end else if (r < 65) begin
            out_stall <= 1'b0;
          end else begin
            out_stall <= 1'b1;
            stall_left = idle_len();
          end
        end
      end
    end
  end

  // sender: present one word and hold it until taken, then maybe idle
  task automatic send_word(input logic [ByteW-1:0] b, input logic fin, input bit fixed,
                           input res_t want);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    cur_fixed = fixed;
    cur_want  = want;
    do @(posedge clk); while (in_stall);
    // no gaps during the long hold, so the block fills up and stalls its input
    gap = hold_active ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_row(input logic [ByteW-1:0] b, input logic fin, input bit fixed,
                         input logic has, input logic [CpW-1:0] cp, input status_t st);
    stim_row_t row;
    row.b                 = b;
    row.fin               = fin;
    row.fixed             = fixed;
    row.want              = '0;
    row.want.has          = has;
    row.want.code_point   = cp;
    row.want.status       = st;
    row.want.stream_end   = fin;
    dir_rows = {dir_rows, row};
  endtask

  initial begin : stimulus
    int               rnd_words;
    int               kind;
    int               len;
    int               cut;
    int               brk;
    int               k;
    bit               hold_done;
    bit               drain_done;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] lead_hi;
    logic             fin;

    n_errors   = 0;
    hold_req   = 1'b0;
    cur_fixed  = 1'b0;
    cur_want   = '0;
    seq_acc    = '0;
    seq_left   = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    last_byte  = 1'b0;
    rnd_words  = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    // synchronous reset, released on a falling edge
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: byte, last, typed-in?, has result, code point, status
    add_row(8'h00, 1'b0, 1, 1'b1, 31'h0,        StOk);      // nul straight after reset
    add_row(8'h7F, 1'b0, 1, 1'b1, 31'h7F,       StOk);      // top of ascii
    add_row(8'hFE, 1'b0, 1, 1'b1, 31'h0,        StBadLead); // 1111111x leads
    add_row(8'hFF, 1'b0, 1, 1'b1, 31'h0,        StBadLead);
    add_row(8'hC0, 1'b0, 1, 1'b0, 31'h0,        StOk);      // exact two-byte lead, overlong zero
    add_row(8'h80, 1'b0, 1, 1'b1, 31'h0,        StOk);
    add_row(8'hDF, 1'b0, 1, 1'b0, 31'h0,        StOk);      // largest two-byte value
    add_row(8'hBF, 1'b0, 1, 1'b1, 31'h7FF,      StOk);
    add_row(8'hE0, 1'b0, 0, 1'b0, 31'h0,        StOk);      // three bytes, predictor
    add_row(8'hA5, 1'b0, 0, 1'b0, 31'h0,        StOk);
    add_row(8'h9C, 1'b0, 0, 1'b0, 31'h0,        StOk);
    add_row(8'hFD, 1'b0, 1, 1'b0, 31'h0,        StOk);      // six bytes, all ones payload
    add_row(8'hBF, 1'b0, 1, 1'b0, 31'h0,        StOk);
    add_row(8'hBF, 1'b0, 1, 1'b0, 31'h0,        StOk);
    add_row(8'hBF, 1'b0, 1, 1'b0, 31'h0,        StOk);
    add_row(8'hBF, 1'b0, 1, 1'b0, 31'h0,        StOk);
    add_row(8'hBF, 1'b0, 1, 1'b1, 31'h7FFFFFFF, StOk);
    add_row(8'hF0, 1'b0, 1, 1'b0, 31'h0,        StOk);      // four-byte lead broken by ascii
    add_row(8'h41, 1'b1, 1, 1'b1, 31'h0,        StBadCont); // bad continuation ends the stream
    add_row(8'hF8, 1'b0, 1, 1'b0, 31'h0,        StOk);      // five-byte lead, stream cut short
    add_row(8'h80, 1'b1, 1, 1'b1, 31'h0,        StTrunc);
    add_row(8'h41, 1'b1, 1, 1'b1, 31'h41,       StOk);      // ascii as the last word
    add_row(8'hE5, 1'b1, 1, 1'b1, 31'h0,        StTrunc);   // lead as the last word
    add_row(8'h80, 1'b1, 1, 1'b1, 31'h0,        StBadLead); // stray continuation as the last word

    foreach (dir_rows[i])
      send_word(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].fixed, dir_rows[i].want);

    // random part: mostly well-formed sequences, then cut, broken and noise streams
    while (rnd_words < 1350) begin
      // one long receiver hold while words keep coming
      if (!hold_done && rnd_words >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // one pause on the sending side until everything has drained
      if (!drain_done && rnd_words >= 800) begin
        drain_done = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cps.size() != 0) @(posedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 88) begin
        len = $urandom_range(1, MaxSeqBytes);
        cut = len;
        brk = 0;
        if (kind >= 70 && len > 1) begin
          if (kind < 79) cut = $urandom_range(1, len - 1);
          else brk = $urandom_range(1, len - 1);
        end
        for (k = 0; k < len; k++) begin
          if (k == 0) begin
            if (len == 1) begin
              b = 8'($urandom_range(0, 127));
            end else begin
              lead_hi = 8'hFF << (8 - len);
              b = lead_hi | (8'($urandom_range(0, 255)) & (8'h7F >> len));
            end
          end else if (k == brk) begin
            // anything that is not a continuation word
            do b = 8'($urandom_range(0, 255)); while ((b & ContMask) == ContMark);
          end else begin
            b = ContMark | (8'($urandom_range(0, 255)) & ContBits);
          end
          fin = 1'b0;
          if (k == cut - 1) fin = (cut < len) ? 1'b1 : ($urandom_range(0, 19) == 0);
          send_word(b, fin, 0, '0);
          rnd_words++;
          if (fin || (brk != 0 && k == brk)) break;
        end
      end else begin
        // noise: any byte at all
        b = 8'($urandom_range(0, 255));
        fin = ($urandom_range(0, 7) == 0);
        send_word(b, fin, 0, '0);
        rnd_words++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching the output to catch any stray result
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_cps.size() != 0)
      report_mismatch("results left over", 0, pending_cps.size());

    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/utf8ds_pkg.sv
hw/rtl/utf8ds_in_reg.sv
hw/rtl/utf8ds_core.sv
hw/rtl/utf8ds_out_reg.sv
hw/rtl/utf8_decoder_six_byte.sv
hw/rtl/utf8ds_checker.sv
tb/tb.sv
